// ===== hw/rtl/utt_pkg.sv =====
`timescale 1ns / 1ps
package utt_pkg;

   localparam int TRIG_BITS    = 24;
   localparam int CORDIC_STEPS = 30;
   localparam int ANG_W        = 34;
   localparam int TRIG_W       = 28;
   localparam int DIFF_W       = 33;

   localparam logic signed [ANG_W-1:0] Q30_PI       = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] Q30_HALF_PI  = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] CORDIC_START = 34'sd652032874;
   localparam logic [63:0]             Q30_TWO_PI   = 64'd6746518852;

   localparam logic signed [ANG_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
      34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149,
      34'sd1048575,   34'sd524287,    34'sd262143,    34'sd131071,    34'sd65535,
      34'sd32767,     34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127,       34'sd63,
      34'sd31,        34'sd15,        34'sd7,         34'sd3,         34'sd1
   };

   typedef struct packed {
      logic signed [ANG_W-1:0] x;
      logic signed [ANG_W-1:0] y;
      logic signed [ANG_W-1:0] a;
      logic                    neg;
   } rot_type;

   typedef struct packed {
      logic                     valid;
      logic                     ref_valid;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [19:0]       heading;
      logic signed [19:0]       extra;
      logic signed [23:0]       vr;
      logic signed [23:0]       wr;
   } carry_type;

   typedef struct packed {
      rot_type   robot;
      rot_type   path;
      carry_type carry;
   } cell_type;

   typedef struct packed {
      logic               enabled;
      logic signed [23:0] gain_along;
      logic signed [23:0] gain_cross;
      logic signed [23:0] gain_heading;
      logic signed [23:0] gain_theta;
      logic signed [23:0] gain_extra;
      logic [22:0]        linear_limit;
      logic [22:0]        angular_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_TRACKING_ENABLED,
      REG_GAIN_ALONG,
      REG_GAIN_CROSS,
      REG_GAIN_HEADING,
      REG_GAIN_THETA,
      REG_GAIN_EXTRA,
      REG_LINEAR_LIMIT,
      REG_ANGULAR_LIMIT
   } reg_index_type;

   localparam logic signed [23:0] RST_GAIN_ALONG    = 24'sd131072;
   localparam logic signed [23:0] RST_GAIN_CROSS    = 24'sd65536;
   localparam logic signed [23:0] RST_GAIN_HEADING  = 24'sd203162;
   localparam logic signed [23:0] RST_GAIN_THETA    = 24'sd58982;
   localparam logic signed [23:0] RST_GAIN_EXTRA    = 24'sd0;
   localparam logic [22:0]        RST_LINEAR_LIMIT  = 23'd221513;
   localparam logic [22:0]        RST_ANGULAR_LIMIT = 23'd553779;

endpackage

// ===== hw/rtl/utt_req_if.sv =====
`timescale 1ns / 1ps
interface utt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] robot_x;
   logic signed [31:0] robot_y;
   logic signed [19:0] robot_heading;
   logic signed [19:0] robot_extra;
   logic               reference_valid;
   logic signed [31:0] ref_x;
   logic signed [31:0] ref_y;
   logic signed [19:0] ref_heading;
   logic signed [23:0] ref_linear;
   logic signed [23:0] ref_angular;

   modport source (output valid, robot_x, robot_y, robot_heading, robot_extra,
                   reference_valid, ref_x, ref_y, ref_heading, ref_linear, ref_angular,
                   input ready);
   modport sink (input valid, robot_x, robot_y, robot_heading, robot_extra,
                 reference_valid, ref_x, ref_y, ref_heading, ref_linear, ref_angular,
                 output ready);
endinterface

// ===== hw/rtl/utt_rsp_if.sv =====
`timescale 1ns / 1ps
interface utt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] linear_command;
   logic signed [23:0] angular_command;

   modport source (output valid, linear_command, angular_command, input ready);
   modport sink (input valid, linear_command, angular_command, output ready);
endinterface

// ===== hw/rtl/utt_csr.sv =====
`timescale 1ns / 1ps
module utt_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output utt_pkg::cfg_type cfg
);
   import utt_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_hit;

   assign index     = reg_index_type'(paddr[4:2]);
   assign write_hit = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_hit) begin
         unique case (index)
            REG_TRACKING_ENABLED: cfg_in.enabled       = pwdata[0];
            REG_GAIN_ALONG:       cfg_in.gain_along    = pwdata[23:0];
            REG_GAIN_CROSS:       cfg_in.gain_cross    = pwdata[23:0];
            REG_GAIN_HEADING:     cfg_in.gain_heading  = pwdata[23:0];
            REG_GAIN_THETA:       cfg_in.gain_theta    = pwdata[23:0];
            REG_GAIN_EXTRA:       cfg_in.gain_extra    = pwdata[23:0];
            REG_LINEAR_LIMIT:     cfg_in.linear_limit  = pwdata[22:0];
            REG_ANGULAR_LIMIT:    cfg_in.angular_limit = pwdata[22:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TRACKING_ENABLED: prdata = {31'd0, cfg_ff.enabled};
         REG_GAIN_ALONG:       prdata = {8'd0, cfg_ff.gain_along};
         REG_GAIN_CROSS:       prdata = {8'd0, cfg_ff.gain_cross};
         REG_GAIN_HEADING:     prdata = {8'd0, cfg_ff.gain_heading};
         REG_GAIN_THETA:       prdata = {8'd0, cfg_ff.gain_theta};
         REG_GAIN_EXTRA:       prdata = {8'd0, cfg_ff.gain_extra};
         REG_LINEAR_LIMIT:     prdata = {9'd0, cfg_ff.linear_limit};
         REG_ANGULAR_LIMIT:    prdata = {9'd0, cfg_ff.angular_limit};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled       <= 1'b0;
         cfg_ff.gain_along    <= RST_GAIN_ALONG;
         cfg_ff.gain_cross    <= RST_GAIN_CROSS;
         cfg_ff.gain_heading  <= RST_GAIN_HEADING;
         cfg_ff.gain_theta    <= RST_GAIN_THETA;
         cfg_ff.gain_extra    <= RST_GAIN_EXTRA;
         cfg_ff.linear_limit  <= RST_LINEAR_LIMIT;
         cfg_ff.angular_limit <= RST_ANGULAR_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ===== hw/rtl/utt_wrap.sv =====
`timescale 1ns / 1ps
module utt_wrap #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic signed [19:0] heading,
   output utt_pkg::rot_type rot
);
   import utt_pkg::*;

   localparam int SHIFT               = 30 - FRAC_BITS;
   localparam int MAG_W               = 20;
   localparam int SCALED_W            = MAG_W + SHIFT;
   localparam int PROD_W              = MAG_W + 32;
   localparam int MULT_W              = MAG_W + 33;
   localparam int REM_W               = 34;
   localparam logic [63:0] RECIP_FULL = (64'd1 << (SHIFT + 32)) / Q30_TWO_PI;
   localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
   localparam logic [32:0] TWO_PI_33  = Q30_TWO_PI[32:0];
   localparam logic signed [35:0] PI_36     = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_36 = 36'sd6746518852;

   // stage 1: magnitude and reciprocal product for the quotient estimate
   logic [MAG_W-1:0]  mag_in, mag_ff;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic              neg1_ff;
   // stage 2: remainder, off by at most one period
   logic [MAG_W-1:0]    quo;
   logic [MULT_W-1:0]   multiple;
   logic [SCALED_W-1:0] scaled;
   logic [MULT_W:0]     diff;
   logic [REM_W-1:0]    rem_in, rem_ff;
   logic                neg2_ff;
   // stage 3: exact remainder, sign back, wrap to [-pi, pi]
   logic [REM_W-1:0]   red;
   logic signed [35:0] sgn;
   logic signed [35:0] ang_in, ang_ff;
   // stage 4: fold to [-pi/2, pi/2]
   logic signed [35:0] fold_a;
   rot_type            rot_in, rot_ff;

   assign mag_in  = heading[19] ? (~heading + 20'd1) : heading;
   assign prod_in = mag_in * RECIP;

   assign quo      = prod_ff[PROD_W-1:32];
   assign multiple = quo * TWO_PI_33;
   assign scaled   = {mag_ff, {SHIFT{1'b0}}};
   assign diff     = {{(MULT_W + 1 - SCALED_W){1'b0}}, scaled} - {1'b0, multiple};
   assign rem_in   = diff[REM_W-1:0];

   always_comb begin
      red = (rem_ff >= TWO_PI_33) ? (rem_ff - {1'b0, TWO_PI_33}) : rem_ff;
      sgn = neg2_ff ? -$signed({2'b00, red}) : $signed({2'b00, red});
      if (sgn > PI_36) begin
         ang_in = sgn - TWO_PI_36;
      end else if (sgn < -PI_36) begin
         ang_in = sgn + TWO_PI_36;
      end else begin
         ang_in = sgn;
      end
   end

   always_comb begin
      rot_in.x   = CORDIC_START;
      rot_in.y   = '0;
      rot_in.neg = 1'b1;
      if (ang_ff > 36'(Q30_HALF_PI)) begin
         fold_a = ang_ff - PI_36;
      end else if (ang_ff < -36'(Q30_HALF_PI)) begin
         fold_a = ang_ff + PI_36;
      end else begin
         fold_a     = ang_ff;
         rot_in.neg = 1'b0;
      end
      rot_in.a = fold_a[ANG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         prod_ff <= prod_in;
         neg1_ff <= heading[19];
         rem_ff  <= rem_in;
         neg2_ff <= neg1_ff;
         ang_ff  <= ang_in;
         rot_ff  <= rot_in;
      end
   end

   assign rot = rot_ff;
endmodule

// ===== hw/rtl/utt_cell.sv =====
`timescale 1ns / 1ps
module utt_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  utt_pkg::cell_type cell_d,
   output utt_pkg::cell_type cell_q
);
   import utt_pkg::*;

   cell_type cell_in, cell_ff;

   function automatic rot_type rotate(rot_type r);
      rot_type                 n;
      logic signed [ANG_W-1:0] xs;
      logic signed [ANG_W-1:0] ys;
      xs = $signed(r.x) >>> STEP;
      ys = $signed(r.y) >>> STEP;
      n  = r;
      if (!r.a[ANG_W-1]) begin
         n.x = $signed(r.x) - ys;
         n.y = $signed(r.y) + xs;
         n.a = $signed(r.a) - ATAN_TABLE[STEP];
      end else begin
         n.x = $signed(r.x) + ys;
         n.y = $signed(r.y) - xs;
         n.a = $signed(r.a) + ATAN_TABLE[STEP];
      end
      return n;
   endfunction

   always_comb begin
      cell_in       = cell_d;
      cell_in.robot = rotate(cell_d.robot);
      cell_in.path  = rotate(cell_d.path);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.carry.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;
endmodule

// ===== hw/rtl/utt_law.sv =====
`timescale 1ns / 1ps
module utt_law #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  utt_pkg::cell_type  cell_d,
   input  utt_pkg::cfg_type   cfg,
   output logic               out_valid,
   output logic signed [23:0] linear_command,
   output logic signed [23:0] angular_command
);
   import utt_pkg::*;

   localparam int TRIG_SHIFT = 30 - TRIG_BITS;
   localparam int P_W        = DIFF_W + TRIG_W;
   localparam int E_W        = TRIG_W + 1;
   localparam int EP_W       = E_W + TRIG_W;
   localparam int ERR_SHIFT  = 2 * TRIG_BITS - FRAC_BITS;
   localparam int X_W        = P_W + 1 - TRIG_BITS;
   localparam int QA_W       = EP_W + 1 - ERR_SHIFT;
   localparam int G_W        = X_W + 24;
   localparam int ACC_W      = 64;
   localparam logic signed [ACC_W-1:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

   function automatic logic signed [TRIG_W-1:0] to_trig(logic signed [ANG_W-1:0] v,
                                                        logic neg);
      logic signed [ANG_W-1:0] s;
      s = neg ? -v : v;
      return s[ANG_W-1:TRIG_SHIFT];
   endfunction

   // L0: cosine and sine at Q.TRIG_BITS
   carry_type                c0_ff;
   logic signed [TRIG_W-1:0] qx_ff, qy_ff, qrx_ff, qry_ff;
   // L1: position products and heading-vector error
   carry_type                c1_ff;
   logic signed [P_W-1:0]    pa1_ff, pa2_ff, pc_ff, pd_ff;
   logic signed [TRIG_W-1:0] qrx1_ff, qry1_ff;
   logic signed [E_W-1:0]    ex_ff, ey_ff;
   // L2: along and cross position error, heading-vector products
   carry_type                c2_ff;
   logic signed [P_W:0]      sa_in, sp_in;
   logic signed [X_W-1:0]    xa_ff, xp_ff;
   logic signed [EP_W-1:0]   e1_ff, e2_ff, e3_ff, e4_ff;
   // L3: heading errors and gain terms
   carry_type                c3_ff;
   logic signed [EP_W:0]     qs_a, qs_p;
   logic signed [QA_W-1:0]   qa_ff, qp_ff;
   logic signed [G_W-1:0]    t_along_ff, t_cross_ff, t_xpw_ff;
   logic signed [43:0]       t_theta_ff, t_extra_ff;
   // L4: sums at Q.(2*FRAC_BITS)
   carry_type                c4_ff;
   logic signed [ACC_W-1:0]  lin_in, ang_in, lin_ff, ang_ff;
   logic signed [ACC_W-1:0]  vr_ext, wr_ext;
   // L5: round, clamp and hold for the output
   logic signed [ACC_W-1:0]  lin_r, ang_r, lin_lim, ang_lim, lin_c, ang_c;
   logic                     out_valid_ff;
   logic signed [23:0]       lin_out_ff, ang_out_ff;

   assign sa_in = {pa1_ff[P_W-1], pa1_ff} + {pa2_ff[P_W-1], pa2_ff};
   assign sp_in = {pd_ff[P_W-1], pd_ff} - {pc_ff[P_W-1], pc_ff};
   assign qs_a  = {e1_ff[EP_W-1], e1_ff} + {e2_ff[EP_W-1], e2_ff};
   assign qs_p  = {e4_ff[EP_W-1], e4_ff} - {e3_ff[EP_W-1], e3_ff};

   always_comb begin
      vr_ext = {{(ACC_W - 24){c3_ff.vr[23]}}, c3_ff.vr};
      wr_ext = {{(ACC_W - 24){c3_ff.wr[23]}}, c3_ff.wr};
      lin_in = -t_along_ff - qa_ff * $signed(c3_ff.vr) - t_xpw_ff
               + (vr_ext <<< FRAC_BITS);
      ang_in = -t_cross_ff - $signed(cfg.gain_heading) * qp_ff - t_theta_ff
               - t_extra_ff + (wr_ext <<< FRAC_BITS);
   end

   always_comb begin
      lin_r   = (lin_ff + HALF_LSB) >>> FRAC_BITS;
      ang_r   = (ang_ff + HALF_LSB) >>> FRAC_BITS;
      lin_lim = {{(ACC_W - 23){1'b0}}, cfg.linear_limit};
      ang_lim = {{(ACC_W - 23){1'b0}}, cfg.angular_limit};
      priority if (lin_r > lin_lim) lin_c = lin_lim;
      else if (lin_r < -lin_lim)    lin_c = -lin_lim;
      else                          lin_c = lin_r;
      priority if (ang_r > ang_lim) ang_c = ang_lim;
      else if (ang_r < -ang_lim)    ang_c = -ang_lim;
      else                          ang_c = ang_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.valid  <= 1'b0;
         c1_ff.valid  <= 1'b0;
         c2_ff.valid  <= 1'b0;
         c3_ff.valid  <= 1'b0;
         c4_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         c0_ff  <= cell_d.carry;
         qx_ff  <= to_trig(cell_d.robot.x, cell_d.robot.neg);
         qy_ff  <= to_trig(cell_d.robot.y, cell_d.robot.neg);
         qrx_ff <= to_trig(cell_d.path.x, cell_d.path.neg);
         qry_ff <= to_trig(cell_d.path.y, cell_d.path.neg);

         c1_ff   <= c0_ff;
         pa1_ff  <= c0_ff.dx * qrx_ff;
         pa2_ff  <= c0_ff.dy * qry_ff;
         pc_ff   <= c0_ff.dx * qry_ff;
         pd_ff   <= c0_ff.dy * qrx_ff;
         qrx1_ff <= qrx_ff;
         qry1_ff <= qry_ff;
         ex_ff   <= {qx_ff[TRIG_W-1], qx_ff} - {qrx_ff[TRIG_W-1], qrx_ff};
         ey_ff   <= {qy_ff[TRIG_W-1], qy_ff} - {qry_ff[TRIG_W-1], qry_ff};

         c2_ff <= c1_ff;
         xa_ff <= sa_in[P_W:TRIG_BITS];
         xp_ff <= sp_in[P_W:TRIG_BITS];
         e1_ff <= ex_ff * qrx1_ff;
         e2_ff <= ey_ff * qry1_ff;
         e3_ff <= ex_ff * qry1_ff;
         e4_ff <= ey_ff * qrx1_ff;

         c3_ff      <= c2_ff;
         qa_ff      <= qs_a[EP_W:ERR_SHIFT];
         qp_ff      <= qs_p[EP_W:ERR_SHIFT];
         t_along_ff <= $signed(cfg.gain_along) * xa_ff;
         t_cross_ff <= $signed(cfg.gain_cross) * xp_ff;
         t_xpw_ff   <= xp_ff * c2_ff.wr;
         t_theta_ff <= $signed(cfg.gain_theta) * c2_ff.heading;
         t_extra_ff <= $signed(cfg.gain_extra) * c2_ff.extra;

         c4_ff  <= c3_ff;
         lin_ff <= lin_in;
         ang_ff <= ang_in;

         out_valid_ff <= c4_ff.valid;
         // finished trajectory: zero command
         lin_out_ff   <= c4_ff.ref_valid ? lin_c[23:0] : 24'sd0;
         ang_out_ff   <= c4_ff.ref_valid ? ang_c[23:0] : 24'sd0;
      end
   end

   assign out_valid       = out_valid_ff;
   assign linear_command  = lin_out_ff;
   assign angular_command = ang_out_ff;

   a_lin_in_limit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (lin_out_ff <= $signed({1'b0, cfg.linear_limit}))
                    && (lin_out_ff >= -$signed({1'b0, cfg.linear_limit})))
      else $error("linear command beyond limit");

   a_ang_in_limit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (ang_out_ff <= $signed({1'b0, cfg.angular_limit}))
                    && (ang_out_ff >= -$signed({1'b0, cfg.angular_limit})))
      else $error("angular command beyond limit");
endmodule

// ===== hw/rtl/unicycle_trajectory_tracking_law_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake       Payload
// req_chan  in   valid / ready   pose, extra state, reference point
// rsp_chan  out  valid / ready   linear_command, angular_command
// csr       in   APB psel/pen    eight registers at 4*index
//
// One transaction per cycle while rsp_chan is not holding a result; 4 angle reduction stages,
// 30 CORDIC cells (both headings side by side), 6 error/gain/clamp stages.
// The whole pipe advances together; a held result on rsp_chan freezes it.
// Transactions accepted with tracking disabled produce no result.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their reset values.
module unicycle_trajectory_tracking_law_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   utt_req_if.sink     req_chan,
   utt_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import utt_pkg::*;

   localparam int WRAP_STAGES = 4;

   cfg_type   cfg;
   logic      adv;
   carry_type carry_in;
   carry_type carry_ff [WRAP_STAGES];
   rot_type   wrap_robot, wrap_path;
   cell_type  chain [CORDIC_STEPS + 1];
   logic      out_valid;

   utt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign adv            = !out_valid || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = out_valid;

   always_comb begin
      // drop the transaction here when the controller is off
      carry_in.valid     = req_chan.valid && cfg.enabled;
      carry_in.ref_valid = req_chan.reference_valid;
      carry_in.dx        = {req_chan.robot_x[31], req_chan.robot_x}
                         - {req_chan.ref_x[31], req_chan.ref_x};
      carry_in.dy        = {req_chan.robot_y[31], req_chan.robot_y}
                         - {req_chan.ref_y[31], req_chan.ref_y};
      carry_in.heading   = req_chan.robot_heading;
      carry_in.extra     = req_chan.robot_extra;
      carry_in.vr        = req_chan.ref_linear;
      carry_in.wr        = req_chan.ref_angular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WRAP_STAGES; i++) carry_ff[i].valid <= 1'b0;
      end else if (adv) begin
         carry_ff[0] <= carry_in;
         for (int i = 1; i < WRAP_STAGES; i++) carry_ff[i] <= carry_ff[i-1];
      end
   end

   utt_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_robot (
      .clock   (clock),
      .en      (adv),
      .heading (req_chan.robot_heading),
      .rot     (wrap_robot)
   );

   utt_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_path (
      .clock   (clock),
      .en      (adv),
      .heading (req_chan.ref_heading),
      .rot     (wrap_path)
   );

   assign chain[0] = '{robot: wrap_robot, path: wrap_path, carry: carry_ff[WRAP_STAGES-1]};

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      utt_cell #(.STEP(g)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (adv),
         .cell_d (chain[g]),
         .cell_q (chain[g+1])
      );
   end

   utt_law #(.FRAC_BITS(FRAC_BITS)) u_law (
      .clock           (clock),
      .reset           (reset),
      .en              (adv),
      .cell_d          (chain[CORDIC_STEPS]),
      .cfg             (cfg),
      .out_valid       (out_valid),
      .linear_command  (rsp_chan.linear_command),
      .angular_command (rsp_chan.angular_command)
   );

   a_off_drops: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && !cfg.enabled |=> !carry_ff[0].valid)
      else $error("transaction entered while tracking disabled");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      carry_ff[WRAP_STAGES-1].valid |->
         ($signed(wrap_robot.a) <= Q30_HALF_PI) && ($signed(wrap_robot.a) >= -Q30_HALF_PI)
         && ($signed(wrap_path.a) <= Q30_HALF_PI) && ($signed(wrap_path.a) >= -Q30_HALF_PI))
      else $error("folded angle outside half pi");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv && chain[CORDIC_STEPS].carry.valid |=> $stable(chain[CORDIC_STEPS]))
      else $error("last cell moved during stall");
endmodule

// ===== sim/utt_tracking_checker.sv =====
`timescale 1ns / 1ps
module utt_tracking_checker (
   input  logic        clock,
   input  logic        reset,
   utt_req_if          req_mon,
   utt_rsp_if          rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output int          errors,
   output int          pending,
   output int          commands_seen
);
   import utt_pkg::*;

   typedef struct {
      logic signed [23:0] linear;
      logic signed [23:0] angular;
   } command_type;

   command_type        command_queue[$];
   logic               en;
   logic signed [23:0] k_along, k_cross, k_heading, k_theta, k_extra;
   logic [22:0]        lin_limit, ang_limit;

   // cosine and sine of a Q.16 angle, both in Q.24
   function automatic void heading_cos_sin(input longint ang, output longint c,
                                           output longint s);
      longint a, x, y, nx;
      bit     flip;
      a = ang * 64'sd16384;
      x = longint'(CORDIC_START);
      y = 0;
      flip = 0;
      a = a % longint'(Q30_TWO_PI);
      if (a > longint'(Q30_PI)) a = a - longint'(Q30_TWO_PI);
      if (a < -longint'(Q30_PI)) a = a + longint'(Q30_TWO_PI);
      if (a > longint'(Q30_HALF_PI)) begin
         a = a - longint'(Q30_PI);
         flip = 1;
      end else if (a < -longint'(Q30_HALF_PI)) begin
         a = a + longint'(Q30_PI);
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            a = a - longint'(ATAN_TABLE[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            a = a + longint'(ATAN_TABLE[i]);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x >>> 6;
      s = y >>> 6;
   endfunction

   function automatic logic signed [23:0] round_clamp(input longint acc,
                                                      input logic [22:0] limit);
      longint v, lim;
      v = (acc + 64'sd32768) >>> 16;
      lim = longint'({1'b0, limit});
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[23:0];
   endfunction

   function automatic command_type tracking_command();
      command_type cmd;
      longint dx, dy, th, q1, vr, wr, qx, qy, qrx, qry, ex, ey;
      longint xa, xp, qa, qp, lin, ang;
      th = longint'(req_mon.robot_heading);
      q1 = longint'(req_mon.robot_extra);
      vr = longint'(req_mon.ref_linear);
      wr = longint'(req_mon.ref_angular);
      dx = longint'(req_mon.robot_x) - longint'(req_mon.ref_x);
      dy = longint'(req_mon.robot_y) - longint'(req_mon.ref_y);
      heading_cos_sin(th, qx, qy);
      heading_cos_sin(longint'(req_mon.ref_heading), qrx, qry);
      xa = (dx * qrx + dy * qry) >>> 24;
      xp = (-dx * qry + dy * qrx) >>> 24;
      ex = qx - qrx;
      ey = qy - qry;
      qa = (ex * qrx + ey * qry) >>> 32;
      qp = (-ex * qry + ey * qrx) >>> 32;
      lin = -longint'(k_along) * xa - qa * vr - xp * wr + vr * 64'sd65536;
      ang = -longint'(k_cross) * xp - longint'(k_heading) * qp - longint'(k_theta) * th
            - longint'(k_extra) * q1 + wr * 64'sd65536;
      cmd.linear = round_clamp(lin, lin_limit);
      cmd.angular = round_clamp(ang, ang_limit);
      return cmd;
   endfunction

   always @(posedge clock) begin
      command_type want;
      if (reset) begin
         en = 1'b0;
         k_along = RST_GAIN_ALONG;
         k_cross = RST_GAIN_CROSS;
         k_heading = RST_GAIN_HEADING;
         k_theta = RST_GAIN_THETA;
         k_extra = RST_GAIN_EXTRA;
         lin_limit = RST_LINEAR_LIMIT;
         ang_limit = RST_ANGULAR_LIMIT;
         command_queue.delete();
         errors = 0;
         commands_seen = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_TRACKING_ENABLED: en = pwdata[0];
               REG_GAIN_ALONG:       k_along = pwdata[23:0];
               REG_GAIN_CROSS:       k_cross = pwdata[23:0];
               REG_GAIN_HEADING:     k_heading = pwdata[23:0];
               REG_GAIN_THETA:       k_theta = pwdata[23:0];
               REG_GAIN_EXTRA:       k_extra = pwdata[23:0];
               REG_LINEAR_LIMIT:     lin_limit = pwdata[22:0];
               REG_ANGULAR_LIMIT:    ang_limit = pwdata[22:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            commands_seen++;
            if (command_queue.size() == 0) begin
               $error("unexpected command linear=%0d angular=%0d",
                      rsp_mon.linear_command, rsp_mon.angular_command);
               errors++;
            end else begin
               want = command_queue.pop_front();
               if (rsp_mon.linear_command !== want.linear) begin
                  $error("linear_command expected %0d got %0d", want.linear,
                         rsp_mon.linear_command);
                  errors++;
               end
               if (rsp_mon.angular_command !== want.angular) begin
                  $error("angular_command expected %0d got %0d", want.angular,
                         rsp_mon.angular_command);
                  errors++;
               end
            end
         end
         // predict after the pop so a same-cycle transaction queues behind
         if (req_mon.valid && req_mon.ready && en) begin
            if (!req_mon.reference_valid) begin
               want.linear = '0;
               want.angular = '0;
            end else begin
               want = tracking_command();
            end
            command_queue.push_back(want);
         end
      end
      pending = command_queue.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import utt_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 50;
   localparam int HDG_MAX = 411775;

   typedef struct {
      logic signed [31:0] rx, ry, fx, fy;
      logic signed [19:0] th, q1, fth;
      logic               fvalid;
      logic signed [23:0] vr, wr;
   } tick_type;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite, pready;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          errors, pending, commands_seen;
   int          ticks_sent, ticks_finished, ticks_off, cycles;
   bit          idle_on;

   utt_req_if req_chan();
   utt_rsp_if rsp_chan();

   unicycle_trajectory_tracking_law_unit i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   utt_tracking_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending),
      .commands_seen(commands_seen)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side backpressure in random bursts
   int stall_left;
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_chan.ready <= 1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_chan.ready <= 0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_chan.ready <= 1;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_tick(input tick_type t);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_chan.robot_x <= t.rx;
      req_chan.robot_y <= t.ry;
      req_chan.robot_heading <= t.th;
      req_chan.robot_extra <= t.q1;
      req_chan.reference_valid <= t.fvalid;
      req_chan.ref_x <= t.fx;
      req_chan.ref_y <= t.fy;
      req_chan.ref_heading <= t.fth;
      req_chan.ref_linear <= t.vr;
      req_chan.ref_angular <= t.wr;
      req_chan.valid <= 1;
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      ticks_sent++;
      if (!t.fvalid) ticks_finished++;
   endtask

   function automatic logic signed [19:0] rand_heading();
      if ($urandom_range(0, 9) == 0) return 20'($urandom);
      return 20'($signed($urandom_range(0, 2 * HDG_MAX)) - HDG_MAX);
   endfunction

   // mostly a vehicle close to its reference, sometimes anything at all
   function automatic tick_type rand_tick();
      tick_type t;
      t.fx = $urandom;
      t.fy = $urandom;
      t.fth = rand_heading();
      t.th = rand_heading();
      t.q1 = rand_heading();
      t.fvalid = ($urandom_range(0, 15) != 0);
      if ($urandom_range(0, 3) == 0) begin
         t.rx = $urandom;
         t.ry = $urandom;
         t.vr = 24'($urandom);
         t.wr = 24'($urandom);
      end else begin
         t.rx = 32'(t.fx + $signed($urandom_range(0, 262144)) - 131072);
         t.ry = 32'(t.fy + $signed($urandom_range(0, 262144)) - 131072);
         t.vr = 24'($signed($urandom_range(0, 262144)) - 131072);
         t.wr = 24'($signed($urandom_range(0, 262144)) - 131072);
      end
      return t;
   endfunction

   task automatic set_gains(input logic [23:0] ka, k0, k1, k2, k3,
                            input logic [22:0] lin, ang);
      csr_write(REG_GAIN_ALONG, 32'(ka));
      csr_write(REG_GAIN_CROSS, 32'(k0));
      csr_write(REG_GAIN_HEADING, 32'(k1));
      csr_write(REG_GAIN_THETA, 32'(k2));
      csr_write(REG_GAIN_EXTRA, 32'(k3));
      csr_write(REG_LINEAR_LIMIT, 32'(lin));
      csr_write(REG_ANGULAR_LIMIT, 32'(ang));
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         send_tick(rand_tick());
         if (i == count / 2 && $urandom_range(0, 1) == 0) wait_idle();
      end
      wait_idle();
   endtask

   initial begin
      tick_type t;
      reset = 1;
      cycles = 0;
      idle_on = 1;
      ticks_sent = 0;
      ticks_finished = 0;
      ticks_off = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      rsp_chan.ready = 1;
      req_chan.valid = 0;
      req_chan.robot_x = '0;
      req_chan.robot_y = '0;
      req_chan.robot_heading = '0;
      req_chan.robot_extra = '0;
      req_chan.reference_valid = 0;
      req_chan.ref_x = '0;
      req_chan.ref_y = '0;
      req_chan.ref_heading = '0;
      req_chan.ref_linear = '0;
      req_chan.ref_angular = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // controller off: transactions vanish
      for (int i = 0; i < 5; i++) begin
         send_tick(rand_tick());
         ticks_off++;
      end
      wait_idle();
      csr_write(REG_TRACKING_ENABLED, 32'd1);

      // directed: zero pose, end of trajectory, field extremes
      t = '{default: '0};
      t.fvalid = 1;
      send_tick(t);
      t.fvalid = 0;
      send_tick(t);
      t.fvalid = 1;
      t.rx = 32'sh7fffffff; t.fx = 32'sh80000000;
      t.ry = 32'sh80000000; t.fy = 32'sh7fffffff;
      send_tick(t);
      t.rx = 32'sh80000000; t.fx = 32'sh7fffffff;
      t.ry = 32'sh7fffffff; t.fy = 32'sh80000000;
      send_tick(t);
      t = '{default: '0};
      t.fvalid = 1;
      t.th = 20'(HDG_MAX); t.fth = 20'(-HDG_MAX); t.q1 = 20'(HDG_MAX);
      send_tick(t);
      t.th = 20'(-HDG_MAX); t.fth = 20'(HDG_MAX); t.q1 = 20'(-HDG_MAX);
      send_tick(t);
      t.th = 20'sh7ffff; t.fth = 20'sh80000; t.q1 = 20'sh80000;
      send_tick(t);
      t.th = 20'sh80000; t.fth = 20'sh7ffff; t.q1 = 20'sh7ffff;
      send_tick(t);
      t.th = 20'sd102944; t.fth = -20'sd102944;
      t.vr = 24'sh7fffff; t.wr = 24'sh800000;
      send_tick(t);
      t.vr = 24'sh800000; t.wr = 24'sh7fffff;
      send_tick(t);
      t.rx = 32'sd65536; t.ry = -32'sd65536; t.vr = 24'sd65536; t.wr = -24'sd32768;
      send_tick(t);
      wait_idle();

      random_phase(300);
      set_gains(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
                23'h7fffff, 23'h7fffff);
      random_phase(250);
      set_gains(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000,
                23'd0, 23'd0);
      random_phase(100);
      set_gains(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom), 23'h7fffff, 23'h7fffff);
      random_phase(250);
      set_gains(24'sd131072, 24'sd65536, 24'sd203162, 24'sd58982, -24'sd30000,
                23'($urandom), 23'($urandom));
      random_phase(250);

      // controller off again mid run
      csr_write(REG_TRACKING_ENABLED, 32'd0);
      for (int i = 0; i < 20; i++) begin
         send_tick(rand_tick());
         ticks_off++;
      end
      wait_idle();
      csr_write(REG_TRACKING_ENABLED, 32'd1);

      idle_on = 0;
      set_gains(24'sd131072, 24'sd65536, 24'sd203162, 24'sd58982, 24'sd0,
                23'h7fffff, 23'h7fffff);
      random_phase(300);

      $display("Sent %0d ticks (%0d end of trajectory, %0d with controller off),",
               ticks_sent, ticks_finished, ticks_off);
      $display("checked %0d commands over six gain and limit settings.", commands_seen);
      if (errors == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
